### hw/rtl/pep_pkg.sv
// Package: token/result word types, symbol codes and the precedence table.
package pep_pkg;

	typedef struct packed {
		logic [3:0] token_class;
		logic [1:0] operand_type;
	} in_word_t;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] rule_code;
		logic [2:0] result_type;
		logic [1:0] convert_side;
		logic [2:0] check_kind;
		logic [1:0] error_code;
		logic       last;
	} out_word_t;

	localparam logic [3:0] SYM_TERM = 4'd0;
	localparam logic [3:0] SYM_LPAR = 4'd11;
	localparam logic [3:0] SYM_RPAR = 4'd12;
	localparam logic [3:0] SYM_END  = 4'd13;
	localparam logic [3:0] SYM_E    = 4'd14;
	localparam logic [3:0] SYM_MARK = 4'd15;

	localparam logic [2:0] T_INT   = 3'd0;
	localparam logic [2:0] T_FLOAT = 3'd1;
	localparam logic [2:0] T_STR   = 3'd2;
	localparam logic [2:0] T_UNDEF = 3'd3;
	localparam logic [2:0] T_BOOL  = 3'd4;

	localparam logic [1:0] ACT_SHIFT  = 2'd0;
	localparam logic [1:0] ACT_REDUCE = 2'd1;
	localparam logic [1:0] ACT_ACCEPT = 2'd2;
	localparam logic [1:0] ACT_ERROR  = 2'd3;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_SYNTAX = 2'd1;
	localparam logic [1:0] ERR_TYPE   = 2'd2;
	localparam logic [1:0] ERR_UNDEF  = 2'd3;

	localparam logic [1:0] P_ERR   = 2'd0;
	localparam logic [1:0] P_SHIFT = 2'd1;
	localparam logic [1:0] P_RED   = 2'd2;
	localparam logic [1:0] P_EQ    = 2'd3;

	localparam int MAX_RESULTS = 32;

	// token/symbol class to table column
	function automatic logic [2:0] class_col(input logic [3:0] c);
		logic [2:0] r;
		case (c)
			4'd0: r = 3'd6;
			4'd1, 4'd2: r = 3'd0;
			4'd3, 4'd4: r = 3'd1;
			4'd5, 4'd6, 4'd7, 4'd8: r = 3'd2;
			4'd9, 4'd10: r = 3'd3;
			4'd11: r = 3'd4;
			4'd12: r = 3'd5;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// precedence relation, row = stack top terminal, col = incoming
	function automatic logic [1:0] prec(input logic [2:0] row, input logic [2:0] col);
		logic [15:0] line;
		case (row)
			3'd0: line = {P_RED, P_SHIFT, P_RED, P_SHIFT, P_RED, P_RED, P_SHIFT, P_RED};
			3'd1: line = {P_RED, P_SHIFT, P_RED, P_SHIFT, P_RED, P_RED, P_RED, P_RED};
			3'd2: line = {P_RED, P_SHIFT, P_RED, P_SHIFT, P_RED, P_ERR, P_SHIFT, P_SHIFT};
			3'd3: line = {P_RED, P_SHIFT, P_RED, P_SHIFT, P_ERR, P_SHIFT, P_SHIFT, P_SHIFT};
			3'd4: line = {P_ERR, P_SHIFT, P_EQ, P_SHIFT, P_SHIFT, P_SHIFT, P_SHIFT, P_SHIFT};
			3'd5: line = {P_RED, P_ERR, P_RED, P_ERR, P_RED, P_RED, P_RED, P_RED};
			3'd6: line = {P_RED, P_ERR, P_RED, P_ERR, P_RED, P_RED, P_RED, P_RED};
			default: line = {P_ERR, P_SHIFT, P_ERR, P_SHIFT, P_SHIFT, P_SHIFT, P_SHIFT, P_SHIFT};
		endcase
		return line[col*2 +: 2];
	endfunction

	typedef struct packed {
		logic [3:0] rule;
		logic [2:0] rtype;
		logic [1:0] conv;
		logic [2:0] chk;
		logic [1:0] err;
	} red_t;

	// type rules for E op E, op = symbol 1..10
	function automatic red_t check_binary(input logic [3:0] op, input logic [2:0] l,
			input logic [2:0] r, input logic infn);
		red_t o;
		logic known;
		logic [1:0] widen;
		known = (l != T_UNDEF) && (r != T_UNDEF);
		widen = (l == T_INT) ? 2'd1 : ((r == T_INT) ? 2'd2 : 2'd0);
		o.rule = op + 4'd1;
		o.conv = 2'd0;
		o.chk = 3'd0;
		o.err = ERR_NONE;
		o.rtype = T_INT;
		if (op >= 4'd9) begin
			o.rtype = T_BOOL;
			if (known && l != r) begin
				if (l == T_INT && r == T_FLOAT) o.conv = 2'd1;
				else if (l == T_FLOAT && r == T_INT) o.conv = 2'd2;
				else o.chk = 3'd4;
			end
		end else if (!known) begin
			if (!infn) o.err = ERR_UNDEF;
			else begin
				o.chk = 3'd1;
				o.rtype = (op >= 4'd5) ? T_BOOL : T_UNDEF;
			end
		end else if (op >= 4'd5) begin
			o.rtype = T_BOOL;
			if (l == T_STR && r == T_STR) o.err = ERR_NONE;
			else if (l == T_STR || r == T_STR) o.err = ERR_TYPE;
			else if (l == T_BOOL || r == T_BOOL) o.err = (l == r) ? ERR_NONE : ERR_TYPE;
			else if (l != r) o.conv = widen;
		end else if (op == 4'd1 && l == T_STR && r == T_STR) begin
			o.rule = 4'd7;
			o.rtype = T_STR;
		end else if (l == T_STR || r == T_STR || l == T_BOOL || r == T_BOOL) begin
			o.err = ERR_TYPE;
		end else if (l == T_INT && r == T_INT) begin
			o.rtype = T_INT;
			if (op == 4'd4) begin
				o.rule = 4'd6;
				o.chk = 3'd2;
			end
		end else begin
			o.rtype = T_FLOAT;
			o.conv = widen;
			if (op == 4'd4) o.chk = 3'd3;
		end
		return o;
	endfunction

	// controller to datapath commands
	typedef struct packed {
		logic load_tok;
		logic clear;
		logic shift;
		logic push_eq;
		logic reduce;
	} cmd_t;

	// datapath status
	typedef struct packed {
		logic [1:0] rel;
		logic       accept_ok;
		logic       full2;
		logic       full1;
		logic       bad_tok;
		red_t       red;
		logic [2:0] final_type;
	} sts_t;

endpackage

### hw/rtl/pep_dp.sv
// Datapath: symbol stack in registers, top terminal and handle marker search.
module pep_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_function,
	input  pep_pkg::in_word_t tok,
	input  pep_pkg::cmd_t     cmd,
	output pep_pkg::sts_t     sts
);
	import pep_pkg::*;

	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);

	logic [7:0]    stk_q [STACK_DEPTH];
	logic [PW-1:0] top_q;
	logic [2:0]    final_q;
	in_word_t      tok_q;
	// position of top terminal and of top marker, kept incrementally
	logic [IW-1:0] term_q;
	logic [IW-1:0] mark_q;
	logic [STACK_DEPTH-1:0] is_mark_q;
	logic [STACK_DEPTH-1:0] is_term_q;

	logic [IW-1:0] nmark, nterm;
	logic          nmark_ok;
	logic [7:0]    ha, hb, hc;
	logic [PW-1:0] hlen;
	red_t          rd;

	// search below the marker being removed (priority from top)
	always_comb begin
		nmark = '0;
		nmark_ok = 1'b0;
		nterm = '0;
		for (int i = 1; i < STACK_DEPTH; i++) begin
			if (IW'(i) < mark_q && is_mark_q[i]) begin
				nmark = IW'(i);
				nmark_ok = 1'b1;
			end
			if (IW'(i) < mark_q && is_term_q[i]) nterm = IW'(i);
		end
	end

	// handle decode
	always_comb begin
		ha = stk_q[IW'(mark_q + IW'(1))];
		hb = stk_q[IW'(mark_q + IW'(2))];
		hc = stk_q[IW'(mark_q + IW'(3))];
		hlen = top_q - PW'(mark_q) - PW'(1);
		rd = '{rule: 4'd0, rtype: T_INT, conv: 2'd0, chk: 3'd0, err: ERR_SYNTAX};
		if (mark_q != '0 && is_mark_q[mark_q]) begin
			if (hlen == PW'(1)) begin
				if (ha[3:0] == SYM_TERM)
					rd = '{rule: 4'd0, rtype: ha[6:4], conv: 2'd0, chk: 3'd0, err: ERR_NONE};
			end else if (hlen == PW'(3)) begin
				if (ha[3:0] == SYM_LPAR && hb[3:0] == SYM_E && hc[3:0] == SYM_RPAR)
					rd = '{rule: 4'd1, rtype: hb[6:4], conv: 2'd0, chk: 3'd0, err: ERR_NONE};
				else if (ha[3:0] == SYM_E && hc[3:0] == SYM_E && hb[3:0] >= 4'd1
						&& hb[3:0] <= 4'd10)
					rd = check_binary(hb[3:0], ha[6:4], hc[6:4], in_function);
			end
		end
	end

	// status
	always_comb begin
		logic [2:0] row, col;
		row = class_col(stk_q[term_q][3:0]);
		col = class_col(tok_q.token_class);
		sts.rel = prec(row, col);
		sts.accept_ok = (row == 3'd7) && (col == 3'd7);
		sts.full2 = (top_q + PW'(2)) > PW'(STACK_DEPTH);
		sts.full1 = (top_q + PW'(1)) > PW'(STACK_DEPTH);
		sts.bad_tok = tok_q.token_class > 4'd13;
		sts.red = rd;
		sts.final_type = final_q;
	end

	// payload of the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_q[0] <= {1'b0, T_UNDEF, SYM_END};
		end else begin
			if (cmd.shift) begin
				for (int i = 1; i < STACK_DEPTH; i++) begin
					if (IW'(i) == term_q + IW'(1)) stk_q[i] <= {4'd0, SYM_MARK};
					else if (IW'(i) > term_q + IW'(1) && PW'(i) <= top_q)
						stk_q[i] <= stk_q[i-1];
					else if (PW'(i) == top_q + PW'(1))
						stk_q[i] <= {1'b0, (tok_q.token_class == SYM_TERM) ?
							{1'b0, tok_q.operand_type} : T_UNDEF, tok_q.token_class};
				end
			end else if (cmd.push_eq) begin
				stk_q[top_q[IW-1:0]] <= {1'b0, T_UNDEF, tok_q.token_class};
			end else if (cmd.reduce) begin
				stk_q[mark_q] <= {1'b0, rd.rtype, SYM_E};
			end
			if (cmd.clear) stk_q[0] <= {1'b0, T_UNDEF, SYM_END};
			if (cmd.load_tok) tok_q <= tok;
		end
	end

	// control part of the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= PW'(1);
			final_q <= T_UNDEF;
			term_q <= '0;
			mark_q <= '0;
			is_mark_q <= '0;
			is_term_q <= STACK_DEPTH'(1);
		end else if (cmd.clear) begin
			top_q <= PW'(1);
			final_q <= T_UNDEF;
			term_q <= '0;
			mark_q <= '0;
			is_mark_q <= '0;
			is_term_q <= STACK_DEPTH'(1);
		end else if (cmd.shift) begin
			for (int i = 1; i < STACK_DEPTH; i++) begin
				if (IW'(i) == term_q + IW'(1)) begin
					is_mark_q[i] <= 1'b1;
					is_term_q[i] <= 1'b0;
				end else if (IW'(i) > term_q + IW'(1) && PW'(i) <= top_q) begin
					is_mark_q[i] <= is_mark_q[i-1];
					is_term_q[i] <= is_term_q[i-1];
				end else if (PW'(i) == top_q + PW'(1)) begin
					is_mark_q[i] <= 1'b0;
					is_term_q[i] <= 1'b1;
				end
			end
			top_q <= top_q + PW'(2);
			term_q <= IW'(top_q + PW'(1));
			// a marker above the top terminal moves up one place and stays topmost; otherwise the new one is topmost
			mark_q <= (mark_q > term_q) ? IW'(mark_q + IW'(1)) : IW'(term_q + IW'(1));
		end else if (cmd.push_eq) begin
			is_mark_q[top_q[IW-1:0]] <= 1'b0;
			is_term_q[top_q[IW-1:0]] <= 1'b1;
			top_q <= top_q + PW'(1);
			term_q <= top_q[IW-1:0];
		end else if (cmd.reduce) begin
			is_mark_q[mark_q] <= 1'b0;
			is_term_q[mark_q] <= 1'b0;
			top_q <= PW'(mark_q) + PW'(1);
			final_q <= rd.rtype;
			mark_q <= nmark_ok ? nmark : '0;
			term_q <= nterm;
		end
	end

endmodule

### hw/rtl/pep_ctrl.sv
// Controller: per-token sequencing of reduce/shift/accept/error and output word.
module pep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output pep_pkg::out_word_t out_data,
	output pep_pkg::cmd_t      cmd,
	input  pep_pkg::sts_t      sts
);
	import pep_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_STEP = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic       done_q;
	out_word_t  word_q;
	out_word_t  nw;
	logic       fin;

	// decide one step
	always_comb begin
		cmd = '0;
		nw = '0;
		fin = 1'b1;
		cmd.load_tok = (state_q == S_IDLE) && in_valid;
		if (state_q == S_STEP) begin
			nw.action = ACT_ERROR;
			nw.error_code = ERR_SYNTAX;
			if (sts.bad_tok || cnt_q == 5'(MAX_RESULTS - 1)) begin
				cmd.clear = 1'b1;
			end else begin
				case (sts.rel)
					P_SHIFT: begin
						if (sts.full2) cmd.clear = 1'b1;
						else begin
							cmd.shift = 1'b1;
							nw = '0;
						end
					end
					P_EQ: begin
						if (sts.full1) cmd.clear = 1'b1;
						else begin
							cmd.push_eq = 1'b1;
							nw = '0;
						end
					end
					P_ERR: begin
						cmd.clear = 1'b1;
						if (sts.accept_ok) begin
							nw = '0;
							nw.action = ACT_ACCEPT;
							nw.result_type = sts.final_type;
						end
					end
					default: begin
						if (sts.red.err != ERR_NONE) begin
							cmd.clear = 1'b1;
							nw.error_code = sts.red.err;
						end else begin
							cmd.reduce = 1'b1;
							fin = 1'b0;
							nw = '0;
							nw.action = ACT_REDUCE;
							nw.rule_code = sts.red.rule;
							nw.result_type = sts.red.rtype;
							nw.convert_side = sts.red.conv;
							nw.check_kind = sts.red.chk;
						end
					end
				endcase
			end
			nw.last = fin;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_STEP) word_q <= nw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_STEP;
					cnt_q <= '0;
				end
				S_STEP: begin
					state_q <= S_OUT;
					done_q <= fin;
					cnt_q <= cnt_q + 5'd1;
				end
				S_OUT: if (out_ready) state_q <= done_q ? S_IDLE : S_STEP;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = word_q;

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last == done_q)) else $error("last flag mismatch");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.shift, cmd.push_eq, cmd.reduce, cmd.clear}) <= 1)
		else $error("conflicting stack commands");
	a_reduce_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.action == ACT_REDUCE) |-> !out_data.last)
		else $error("reduce marked last");
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) |=> (state_q == S_OUT)) else $error("step not shown");

endmodule

### hw/rtl/precedence_expression_parser_core.sv
// Top level of the operator-precedence expression parser.
// Usage: tokens enter on in_valid/in_ready as one in_word_t word (class and
// operand type). For each accepted token the block returns one or more
// out_word_t words on out_valid/out_ready: zero or more reductions, then one
// shift, accept or error, the final word flagged by last.
// Each result word takes a decision step and a hand-over step; the next token
// is taken after the last word is handed over. The user writes in_function
// through cfg_we/cfg_wdata only while idle; the block does not enforce this.
// Reset (arst_n low) empties the stack to the bottom end marker and clears
// in_function. A stall on out_ready holds the current word and stops the
// parser; no token is taken until all its results are delivered.
module precedence_expression_parser_core #(
	parameter int STACK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  pep_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pep_pkg::out_word_t out_data
);
	import pep_pkg::*;

	logic in_function_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) in_function_q <= 1'b0;
		else if (cfg_we) in_function_q <= cfg_wdata;
	end

	pep_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_function(in_function_q),
		.tok(in_data), .cmd(cmd), .sts(sts)
	);

	pep_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cmd(cmd), .sts(sts)
	);

endmodule
